// File: rtl/core/amt_spk_pkg.sv
// shared types, constants and reset values for the spoken amount sequencer
package amt_spk_pkg;

	localparam int AMT_W       = 24;
	localparam int FILE_W      = 8;
	localparam int DIGITS      = 7;
	localparam int DIGIT_W     = 4;
	localparam int BCD_W       = DIGITS * DIGIT_W;
	localparam int DD_BITS     = 3;
	localparam int DD_STAGES   = AMT_W / DD_BITS;
	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_IDX_W   = 3;

	localparam logic [AMT_W-1:0]  MAX_AMOUNT  = AMT_W'(9999999);
	localparam logic [FILE_W-1:0] FILE_TEN    = FILE_W'(10);
	localparam logic [FILE_W-1:0] FILE_TWENTY = FILE_W'(20);

	// digit positions of the decimal amount
	localparam int DIG_TH_TENS   = 6;
	localparam int DIG_TH_ONES   = 5;
	localparam int DIG_HUNDREDS  = 4;
	localparam int DIG_DOL_TENS  = 3;
	localparam int DIG_DOL_ONES  = 2;
	localparam int DIG_CENT_TENS = 1;
	localparam int DIG_CENT_ONES = 0;

	typedef logic [DIGIT_W-1:0] digit_t;

	typedef enum logic [3:0] {
		SLOT_PROMPT,
		SLOT_ZERO,
		SLOT_TH_FIRST,
		SLOT_TH_ONES,
		SLOT_THOUSAND,
		SLOT_HUND_DIGIT,
		SLOT_HUNDRED,
		SLOT_REST_FIRST,
		SLOT_REST_ONES,
		SLOT_DOLLAR,
		SLOT_CENT_FIRST,
		SLOT_CENT_ONES,
		SLOT_CENT
	} slot_t;

	localparam int NUM_SLOTS = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROMPT,
		REG_ZERO,
		REG_HUNDRED,
		REG_THOUSAND,
		REG_DOLLAR_ONE,
		REG_DOLLAR_MANY,
		REG_CENT_ONE,
		REG_CENT_MANY
	} reg_idx_t;

	typedef struct packed {
		logic [FILE_W-1:0] prompt;
		logic [FILE_W-1:0] zero;
		logic [FILE_W-1:0] hundred;
		logic [FILE_W-1:0] thousand;
		logic [FILE_W-1:0] dollar_one;
		logic [FILE_W-1:0] dollar_many;
		logic [FILE_W-1:0] cent_one;
		logic [FILE_W-1:0] cent_many;
	} file_cfg_t;

	localparam file_cfg_t CFG_RESET = '{
		prompt:      FILE_W'(31),
		zero:        FILE_W'(34),
		hundred:     FILE_W'(28),
		thousand:    FILE_W'(29),
		dollar_one:  FILE_W'(32),
		dollar_many: FILE_W'(33),
		cent_one:    FILE_W'(30),
		cent_many:   FILE_W'(31)
	};

	typedef struct packed {
		logic [NUM_SLOTS-1:0]       mask;
		digit_t [DIGITS-1:0]        digits;
		logic                       dollar_one;
		logic                       cent_one;
	} plan_t;

endpackage

// File: rtl/core/amt_spk_queue.sv
// small flip-flop queue between the front and back parts
module amt_spk_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: rtl/core/amt_spk_front.sv
// front part: saturates the amount, converts it to decimal and plans the words
module amt_spk_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [amt_spk_pkg::AMT_W-1:0]         amount,
	output logic                                  push,
	output amt_spk_pkg::plan_t                    plan,
	input  logic                                  q_full
);
	import amt_spk_pkg::*;

	function automatic logic [BCD_W-1:0] dd_three(
		input logic [BCD_W-1:0]   bcd,
		input logic [DD_BITS-1:0] bits
	);
		logic [BCD_W-1:0] r;
		r = bcd;
		for (int j = DD_BITS - 1; j >= 0; j--) begin
			for (int i = 0; i < DIGITS; i++) begin
				if (r[DIGIT_W*i +: DIGIT_W] >= 4'd5) begin
					r[DIGIT_W*i +: DIGIT_W] = r[DIGIT_W*i +: DIGIT_W] + 4'd3;
				end
			end
			r = {r[BCD_W-2:0], bits[j]};
		end
		return r;
	endfunction

	logic [DD_STAGES:0] vld_s;
	logic [AMT_W-1:0]   bin_s [DD_STAGES];
	logic [BCD_W-1:0]   bcd_s [1:DD_STAGES];
	logic               en;
	digit_t [DIGITS-1:0] d;
	logic               th_nz;
	logic               dol_nz;
	logic               rest_nz;
	logic               cent_nz;

	assign en       = !vld_s[DD_STAGES] || !q_full;
	assign in_ready = en;
	assign push     = vld_s[DD_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DD_STAGES-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bin_s[0] <= (amount > MAX_AMOUNT) ? MAX_AMOUNT : amount;
			bcd_s[1] <= dd_three('0, bin_s[0][AMT_W-1 -: DD_BITS]);
			for (int k = 1; k < DD_STAGES; k++) begin
				bin_s[k]   <= bin_s[k-1] << DD_BITS;
				bcd_s[k+1] <= dd_three(bcd_s[k], bin_s[k][AMT_W-1 -: DD_BITS]);
			end
		end
	end

	assign d = bcd_s[DD_STAGES];

	always_comb begin
		th_nz   = (d[DIG_TH_TENS] != '0) || (d[DIG_TH_ONES] != '0);
		rest_nz = (d[DIG_DOL_TENS] != '0) || (d[DIG_DOL_ONES] != '0);
		dol_nz  = th_nz || (d[DIG_HUNDREDS] != '0) || rest_nz;
		cent_nz = (d[DIG_CENT_TENS] != '0) || (d[DIG_CENT_ONES] != '0);

		plan.mask                  = '0;
		plan.mask[SLOT_PROMPT]     = 1'b1;
		plan.mask[SLOT_ZERO]       = !dol_nz && !cent_nz;
		plan.mask[SLOT_TH_FIRST]   = th_nz;
		plan.mask[SLOT_TH_ONES]    = (d[DIG_TH_TENS] >= 4'd2) && (d[DIG_TH_ONES] != '0);
		plan.mask[SLOT_THOUSAND]   = th_nz;
		plan.mask[SLOT_HUND_DIGIT] = (d[DIG_HUNDREDS] != '0);
		plan.mask[SLOT_HUNDRED]    = (d[DIG_HUNDREDS] != '0);
		plan.mask[SLOT_REST_FIRST] = rest_nz;
		plan.mask[SLOT_REST_ONES]  = (d[DIG_DOL_TENS] >= 4'd2) && (d[DIG_DOL_ONES] != '0);
		plan.mask[SLOT_DOLLAR]     = dol_nz || !cent_nz;
		plan.mask[SLOT_CENT_FIRST] = cent_nz;
		plan.mask[SLOT_CENT_ONES]  = (d[DIG_CENT_TENS] >= 4'd2) && (d[DIG_CENT_ONES] != '0);
		plan.mask[SLOT_CENT]       = cent_nz;

		plan.digits     = d;
		plan.dollar_one = !th_nz && (d[DIG_HUNDREDS] == '0) && (d[DIG_DOL_TENS] == '0)
			&& (d[DIG_DOL_ONES] == 4'd1);
		plan.cent_one   = (d[DIG_CENT_TENS] == '0) && (d[DIG_CENT_ONES] == 4'd1);
	end

endmodule

// File: rtl/core/amt_spk_back.sv
// back part: walks the planned words of one amount and drives the output register
module amt_spk_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  amt_spk_pkg::plan_t                q_plan,
	output logic                              q_pop,
	input  amt_spk_pkg::file_cfg_t            cfg,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [amt_spk_pkg::FILE_W-1:0]    track_number,
	output logic                              last_word
);
	import amt_spk_pkg::*;

	function automatic logic [FILE_W-1:0] pair_first(input digit_t t, input digit_t o);
		logic [FILE_W-1:0] r;
		if (t >= 4'd2) begin
			r = FILE_TWENTY + FILE_W'(t) - FILE_W'(2);
		end else if (t == 4'd1) begin
			r = FILE_TEN + FILE_W'(o);
		end else begin
			r = FILE_W'(o);
		end
		return r;
	endfunction

	logic [NUM_SLOTS-1:0] mask_q;
	digit_t [DIGITS-1:0]  dig_q;
	logic                 dollar_one_q;
	logic                 cent_one_q;
	logic                 out_valid_q;
	logic [FILE_W-1:0]    track_q;
	logic                 last_q;

	logic                 busy;
	logic                 adv;
	logic                 take;
	logic                 load;
	logic [NUM_SLOTS-1:0] rem;
	slot_t                slot;
	logic [FILE_W-1:0]    word;

	assign busy  = |mask_q;
	assign adv   = !out_valid_q || out_ready;
	assign take  = adv && busy;
	assign rem   = mask_q & (mask_q - NUM_SLOTS'(1));
	assign load  = q_valid && (!busy || (take && (rem == '0)));
	assign q_pop = load;

	always_comb begin
		slot = SLOT_PROMPT;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				slot = slot_t'(4'(i));
			end
		end
	end

	always_comb begin
		case (slot)
			SLOT_PROMPT:     word = cfg.prompt;
			SLOT_ZERO:       word = cfg.zero;
			SLOT_TH_FIRST:   word = pair_first(dig_q[DIG_TH_TENS], dig_q[DIG_TH_ONES]);
			SLOT_TH_ONES:    word = FILE_W'(dig_q[DIG_TH_ONES]);
			SLOT_THOUSAND:   word = cfg.thousand;
			SLOT_HUND_DIGIT: word = FILE_W'(dig_q[DIG_HUNDREDS]);
			SLOT_HUNDRED:    word = cfg.hundred;
			SLOT_REST_FIRST: word = pair_first(dig_q[DIG_DOL_TENS], dig_q[DIG_DOL_ONES]);
			SLOT_REST_ONES:  word = FILE_W'(dig_q[DIG_DOL_ONES]);
			SLOT_DOLLAR:     word = dollar_one_q ? cfg.dollar_one : cfg.dollar_many;
			SLOT_CENT_FIRST: word = pair_first(dig_q[DIG_CENT_TENS], dig_q[DIG_CENT_ONES]);
			SLOT_CENT_ONES:  word = FILE_W'(dig_q[DIG_CENT_ONES]);
			SLOT_CENT:       word = cent_one_q ? cfg.cent_one : cfg.cent_many;
			default:         word = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				mask_q <= q_plan.mask;
			end else if (take) begin
				mask_q <= rem;
			end
			if (adv) begin
				out_valid_q <= busy;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dig_q        <= q_plan.digits;
			dollar_one_q <= q_plan.dollar_one;
			cent_one_q   <= q_plan.cent_one;
		end
		if (take) begin
			track_q <= word;
			last_q  <= (rem == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign track_number = track_q;
	assign last_word    = last_q;

endmodule

// File: rtl/core/amount_to_spoken_word_sequence.sv
// top level of the spoken amount sequencer with its file number registers
// Takes an amount in cents (saturated at 9,999,999) and emits the voice prompt file numbers
// that speak it, one word per output transfer, with last_word set on the final word.
// An amount passes through the front pipeline (one saturation stage, then eight
// binary-to-decimal stages of three bits each), which accepts a new amount every cycle
// unless its last stage holds a plan and the queue is full; planned amounts wait in a
// QUEUE_DEPTH-entry queue. The back part emits one word per cycle through its output
// register unless out_ready holds it, so an amount takes as many transfers as it has
// words: 3 to 12. File number registers are written through the always-ready cfg channel.
module amount_to_spoken_word_sequence #(
	parameter int QUEUE_DEPTH = amt_spk_pkg::QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [amt_spk_pkg::AMT_W-1:0]       amount,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [amt_spk_pkg::FILE_W-1:0]      track_number,
	output logic                                last_word,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [amt_spk_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [amt_spk_pkg::FILE_W-1:0]      cfg_data
);
	import amt_spk_pkg::*;

	file_cfg_t cfg_q;
	plan_t     front_plan;
	plan_t     q_plan;
	logic      push;
	logic      q_full;
	logic      q_empty;
	logic      q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_PROMPT:      cfg_q.prompt      <= cfg_data;
				REG_ZERO:        cfg_q.zero        <= cfg_data;
				REG_HUNDRED:     cfg_q.hundred     <= cfg_data;
				REG_THOUSAND:    cfg_q.thousand    <= cfg_data;
				REG_DOLLAR_ONE:  cfg_q.dollar_one  <= cfg_data;
				REG_DOLLAR_MANY: cfg_q.dollar_many <= cfg_data;
				REG_CENT_ONE:    cfg_q.cent_one    <= cfg_data;
				REG_CENT_MANY:   cfg_q.cent_many   <= cfg_data;
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	amt_spk_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.amount   (amount),
		.push     (push),
		.plan     (front_plan),
		.q_full   (q_full)
	);

	amt_spk_queue #(
		.WIDTH ($bits(plan_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_plan),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_plan),
		.empty  (q_empty)
	);

	amt_spk_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (!q_empty),
		.q_plan       (q_plan),
		.q_pop        (q_pop),
		.cfg          (cfg_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.track_number (track_number),
		.last_word    (last_word)
	);

endmodule
